@@ rtl/tlru_pkg.sv @@
`default_nettype none
package tlru_pkg;

  // Default number of cache sets.
  localparam int unsigned TLRU_SETS = 256;

  // Field widths.
  localparam int unsigned SET_IDX_W = 8;
  localparam int unsigned WAY_W     = 3;
  localparam int unsigned SLOTS     = 8;
  localparam int unsigned LIST_W    = SLOTS * WAY_W;

  // Highest active slot in 8-way and in 4-way mode.
  localparam logic [WAY_W-1:0] SLOT_LAST_8 = 3'h7;
  localparam logic [WAY_W-1:0] SLOT_LAST_4 = 3'h3;

  // Depth of the command queue between the front and back parts.
  localparam int unsigned QDEPTH = 2;

  // Request codes carried in the mode field.
  localparam logic MODE_ACCESS = 1'b0;
  localparam logic MODE_VICTIM = 1'b1;

  // One order list: slot j in bits 3j+2..3j, slot 0 is least recently used.
  typedef logic [SLOTS-1:0][WAY_W-1:0] order_list_t;

  // Order list after reset: slot j holds way j.
  localparam order_list_t INIT_LIST = 24'o76543210;

  // Classified command handed from the front part to the back part.
  typedef struct packed {
    logic                 is_access;
    logic                 in_range;
    logic [SET_IDX_W-1:0] set_index;
    logic [WAY_W-1:0]     way;
  } cmd_t;

  // Back part sequencer states.
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_UPDATE
  } bk_state_t;

endpackage
`default_nettype wire

@@ rtl/tlru_front.sv @@
`default_nettype none
module tlru_front #(
  parameter int unsigned SETS = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_mode,
  input  wire logic [tlru_pkg::SET_IDX_W-1:0] in_set_index,
  input  wire logic [tlru_pkg::WAY_W-1:0]     in_way,
  input  wire logic                           clearing,
  output logic                                q_valid,
  output tlru_pkg::cmd_t                      q_cmd,
  input  wire logic                           q_pop
);
  import tlru_pkg::*;

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  cmd_t             q_mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] q_cnt_r, q_cnt_nxt;
  logic             push;
  cmd_t             cmd_in;

  // Classify the incoming beat: access or victim request, set in range or not.
  always_comb begin
    cmd_in.is_access = (in_mode == MODE_ACCESS);
    cmd_in.in_range  = (32'(in_set_index) < 32'(SETS));
    cmd_in.set_index = in_set_index;
    cmd_in.way       = in_way;
  end

  // No beats are taken while the back part sweeps the order lists.
  assign in_ready = !clearing && (q_cnt_r < CNT_W'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (q_cnt_r != '0);
  assign q_cmd    = q_mem[rd_ptr_r];

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    q_cnt_nxt  = q_cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      q_cnt_nxt = q_cnt_r + 1'b1;
    end else if (q_pop && !push) begin
      q_cnt_nxt = q_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd_in;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= CNT_W'(QDEPTH))
    else $error("command queue overfilled");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_cnt_r != '0)
    else $error("command queue popped while empty");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !push)
    else $error("beat taken during the clearing sweep");

endmodule
`default_nettype wire

@@ rtl/tlru_back.sv @@
`default_nettype none
module tlru_back #(
  parameter int unsigned SETS = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       eight_ways,
  input  wire logic                       q_valid,
  input  wire tlru_pkg::cmd_t             q_cmd,
  output logic                            q_pop,
  output logic                            clearing,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [tlru_pkg::WAY_W-1:0]      out_victim_way
);
  import tlru_pkg::*;

  localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;

  order_list_t       mem [SETS];
  bk_state_t         state_r, state_nxt;
  logic [SET_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  cmd_t              cmd_r, cmd_nxt;
  order_list_t       rd_data_r;
  logic              out_valid_r, out_valid_nxt;
  logic [WAY_W-1:0]  out_victim_r, out_victim_nxt;

  logic              mem_we, mem_re;
  logic [SET_W-1:0]  mem_waddr, mem_raddr;
  order_list_t       mem_wdata;
  logic              out_load_ok;

  logic [WAY_W-1:0]  last_slot;
  logic [SLOTS-1:0]  match;
  logic              found_any;
  logic [WAY_W-1:0]  found_slot;
  order_list_t       new_list;
  logic [WAY_W-1:0]  victim;

  // Locate the accessed way among the active slots.
  always_comb begin
    last_slot  = eight_ways ? SLOT_LAST_8 : SLOT_LAST_4;
    found_slot = '0;
    for (int s = 0; s < SLOTS; s++) begin
      match[s] = (rd_data_r[s] == cmd_r.way) && (WAY_W'(s) <= last_slot);
    end
    found_any = |match;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (match[s]) begin
        found_slot = WAY_W'(s);
      end
    end
  end

  // Move the accessed way to the most recent end; later slots shift down.
  always_comb begin
    new_list = rd_data_r;
    if (cmd_r.is_access && found_any) begin
      for (int s = 0; s < SLOTS - 1; s++) begin
        if (WAY_W'(s) >= found_slot && WAY_W'(s) < last_slot) begin
          new_list[s] = rd_data_r[s+1];
        end
      end
      new_list[last_slot] = cmd_r.way;
    end
  end

  // Victim is slot 0 after the update, two bits wide in 4-way mode; way 0 for a set out of range.
  always_comb begin
    if (!cmd_r.in_range) begin
      victim = '0;
    end else if (eight_ways) begin
      victim = new_list[0];
    end else begin
      victim = {1'b0, new_list[0][1:0]};
    end
  end

  assign out_load_ok    = !out_valid_r || out_ready;
  assign clearing       = (state_r == BK_CLEAR);
  assign out_valid      = out_valid_r;
  assign out_victim_way = out_victim_r;

  // Sequencer: clearing sweep, read of the set's list, then update and result.
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    cmd_nxt        = cmd_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_victim_nxt = out_victim_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = SET_W'(cmd_r.set_index);
    mem_raddr      = SET_W'(q_cmd.set_index);
    mem_wdata      = new_list;
    unique case (state_r)
      BK_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = INIT_LIST;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == SET_W'(SETS - 1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          mem_re    = 1'b1;
          cmd_nxt   = q_cmd;
          state_nxt = BK_UPDATE;
        end
      end
      BK_UPDATE: begin
        if (out_load_ok) begin
          mem_we         = cmd_r.is_access && cmd_r.in_range;
          out_valid_nxt  = 1'b1;
          out_victim_nxt = victim;
          state_nxt      = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    out_victim_r <= out_victim_nxt;
  end

  // Order list memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  a_pop_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == BK_IDLE)
    else $error("command popped outside the idle state");

  a_no_write_oor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_UPDATE && !cmd_r.in_range) |-> !mem_we)
    else $error("order list written for a set out of range");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_UPDATE && out_load_ok && !cmd_r.in_range) |=> out_victim_way == '0)
    else $error("nonzero victim for a set out of range");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_CLEAR) |-> (!out_valid_r && !q_pop))
    else $error("activity during the clearing sweep");

endmodule
`default_nettype wire

@@ rtl/true_lru_order_per_set.sv @@
// True LRU replacement order, one 8-slot order list per cache set.
// Input channel (in_valid/in_ready): in_mode selects an access to in_way
// (moved to the most recent end of the set's list) or a victim request
// (list left unchanged). in_set_index names the set.
// Output channel (out_valid/out_ready): one beat per input beat, in order,
// carrying the set's least recently used way after the step. In 4-way mode
// it is given in the low 2 bits; a set beyond SETS yields way 0.
// Configuration channel (cfg_valid/cfg_ready): cfg_eight_ways selects 8-way
// (1) or 4-way (0) operation; write it only while the block is idle.
// A beat passes the command queue, the registered read of the order list
// and the result register. The back end handles one command at a time: a
// read-modify-write of the order list memory: registered read, then write.
// A 2-entry command queue lets the input side take beats while the back end
// waits on a stalled receiver; the result register holds until taken.
// Reset: the order lists are swept back to "slot j holds way j", one set a
// cycle, over all SETS sets, during which in_ready is low. eight_ways resets to 1.
`default_nettype none
module true_lru_order_per_set #(
  parameter int unsigned SETS = tlru_pkg::TLRU_SETS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_mode,
  input  wire logic [tlru_pkg::SET_IDX_W-1:0] in_set_index,
  input  wire logic [tlru_pkg::WAY_W-1:0]     in_way,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [tlru_pkg::WAY_W-1:0]          out_victim_way,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic                           cfg_eight_ways
);
  import tlru_pkg::*;

  logic eight_ways_r, eight_ways_nxt;
  logic q_valid, q_pop, clearing;
  cmd_t q_cmd;

  // Associativity register.
  assign cfg_ready = 1'b1;

  always_comb begin
    eight_ways_nxt = eight_ways_r;
    if (cfg_valid && cfg_ready) begin
      eight_ways_nxt = cfg_eight_ways;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eight_ways_r <= 1'b1;
    end else begin
      eight_ways_r <= eight_ways_nxt;
    end
  end

  // Front part: takes and classifies beats into the command queue.
  tlru_front #(.SETS(SETS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_set_index (in_set_index),
    .in_way       (in_way),
    .clearing     (clearing),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop)
  );

  // Back part: order list memory, update logic and result register.
  tlru_back #(.SETS(SETS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .eight_ways     (eight_ways_r),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_victim_way (out_victim_way)
  );

endmodule
`default_nettype wire
